>>> hw/rtl/pjst_pkg.sv
// Shared types, codes and constants for the priority job slot table.
`default_nettype none
package pjst_pkg;

    localparam int SLOTS_DEFAULT = 32;

    // command codes
    localparam logic [2:0] CMD_LAUNCH = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_KILL   = 3'd2;
    localparam logic [2:0] CMD_RUN    = 3'd3;
    localparam logic [2:0] CMD_REPORT = 3'd4;
    localparam logic [2:0] CMD_PURGE  = 3'd5;

    // result codes
    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_FULL      = 3'd1;
    localparam logic [2:0] RC_MISS      = 3'd2;
    localparam logic [2:0] RC_NO_EFFECT = 3'd3;
    localparam logic [2:0] RC_START_BAD = 3'd4;
    localparam logic [2:0] RC_NO_RUN    = 3'd5;

    localparam logic [9:0]  ST_DONE_MIN   = 10'd1005;
    localparam logic [14:0] ST_RUN_MAX    = 15'd1004;
    localparam logic [14:0] ST_DONE_MIN15 = 15'd1005;
    localparam logic [14:0] ST_MISS       = 15'd1016;
    localparam logic [14:0] ST_NEG_CLAMP  = 15'd1019;
    localparam logic [9:0]  KILL_RESET    = 10'd1010;
    localparam logic [12:0] HANDLE_BASE   = 13'h0fe0;
    localparam logic [11:0] HANDLE_STEP   = 12'd32;
    localparam logic [15:0] NEG_LIMIT_LO  = 16'hffed;  // low bits of -19
    localparam logic [15:0] REPORT_MIN    = 16'd32767;

    typedef struct packed {
        logic capture;
        logic exec;
        logic ins_step;
        logic scan_step;
        logic purge_step;
        logic out_load;
        logic idle;
    } t_dp_cmd;

    typedef struct packed {
        logic launch_ins;
        logic is_run;
        logic is_purge;
        logic ins_done;
        logic scan_done;
        logic purge_done;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> hw/rtl/priority_job_slot_table.sv
// Top level of the priority job slot table: sequencer plus datapath.
`default_nettype none
// Job table of SLOTS slots with generation-tagged 12-bit handles (bit 12 of a
// stored handle marks it dead) and a run list ordered by priority class, ties
// kept in launch order. One command word in gives one result word out. Lookup,
// kill, job report, unused codes, a full table and a failed start go from the
// execute step straight to the finish step, which loads the output register.
// A launch that starts goes through an insert step that shifts run-list
// entries up until its place is found, run step scans the list for the first
// entry with a runnable status, and purge walks the whole list; each walk
// reads one key per cycle. The finish step waits while the output register
// holds a word that has not been taken.
// A new command word is taken only when the previous one has been moved to
// the output register, which can hold a result while the next command runs.
// kill_status is to be written with i_cfg_we / i_cfg_data only while the
// block is idle; the block itself does not enforce this.
// No clearing pass after reset: the block is ready once reset is released.
module priority_job_slot_table #(
    parameter int SLOTS = pjst_pkg::SLOTS_DEFAULT
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // command channel
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [2:0]         i_cmd,
    input  wire  [12:0]        i_handle,
    input  wire                i_start_ok,
    input  wire  [2:0]         i_priority_class,
    input  wire  signed [16:0] i_status_in,
    // result channel
    output logic               o_valid,
    input  wire                i_ready,
    output logic [2:0]         o_result_code,
    output logic [11:0]        o_handle_out,
    output logic [4:0]         o_slot_out,
    output logic [14:0]        o_job_status,
    output logic [5:0]         o_active_count,
    // kill_status register
    input  wire                i_cfg_we,
    input  wire  [9:0]         i_cfg_data
);

    pjst_pkg::t_dp_cmd  dp_cmd;
    pjst_pkg::t_dp_stat dp_stat;

    pjst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    pjst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd_code       (i_cmd),
        .i_handle         (i_handle),
        .i_start_ok       (i_start_ok),
        .i_priority_class (i_priority_class),
        .i_status_in      (i_status_in),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_result_code    (o_result_code),
        .o_handle_out     (o_handle_out),
        .o_slot_out       (o_slot_out),
        .o_job_status     (o_job_status),
        .o_active_count   (o_active_count)
    );

endmodule
`default_nettype wire

>>> hw/rtl/pjst_ctrl.sv
// Command sequencer for the priority job slot table.
`default_nettype none
module pjst_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  pjst_pkg::t_dp_stat i_stat,
    output pjst_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_INSERT, S_SCAN, S_PURGE, S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle    = 1'b1;
                o_cmd.capture = i_valid && i_rst_n;
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_stat.launch_ins) n_state = S_INSERT;
                else if (i_stat.is_run)         n_state = S_SCAN;
                else if (i_stat.is_purge)       n_state = S_PURGE;
                else                            n_state = S_FINISH;
            end
            S_INSERT: begin
                o_cmd.ins_step = 1'b1;
                if (i_stat.ins_done) n_state = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) n_state = S_FINISH;
            end
            S_PURGE: begin
                o_cmd.purge_step = 1'b1;
                if (i_stat.purge_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.out_load = i_stat.out_free;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // not ready while reset is held, so no word is taken then
    assign o_ready = (r_state == S_IDLE) && i_rst_n;

endmodule
`default_nettype wire

>>> hw/rtl/pjst_dp.sv
// Slot arrays, run list, command execution and output register.
`default_nettype none
module pjst_dp #(
    parameter int SLOTS = pjst_pkg::SLOTS_DEFAULT
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  pjst_pkg::t_dp_cmd  i_cmd,
    output pjst_pkg::t_dp_stat o_stat,
    input  wire                i_cfg_we,
    input  wire  [9:0]         i_cfg_data,
    input  wire  [2:0]         i_cmd_code,
    input  wire  [12:0]        i_handle,
    input  wire                i_start_ok,
    input  wire  [2:0]         i_priority_class,
    input  wire  signed [16:0] i_status_in,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_result_code,
    output logic [11:0]        o_handle_out,
    output logic [4:0]         o_slot_out,
    output logic [14:0]        o_job_status,
    output logic [5:0]         o_active_count
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [12:0] r_hdl  [SLOTS];
    logic [14:0] r_stat [SLOTS];
    logic [SLOTS-1:0] r_job;
    logic [SLOTS-1:0] r_used;
    logic [7:0]  r_key  [SLOTS];
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_keep;
    logic [CW-1:0] r_act;
    logic [IW-1:0] r_slot;
    logic [9:0]  r_kill;

    logic [2:0]  r_cmd;
    logic [12:0] r_h;
    logic        r_ok;
    logic [2:0]  r_pc;
    logic signed [16:0] r_sv;

    logic [2:0]  r_res_code;
    logic [11:0] r_res_hdl;
    logic [4:0]  r_res_slot;
    logic [14:0] r_res_stat;
    logic [5:0]  r_res_act;

    logic        r_out_valid;
    logic [2:0]  r_out_code;
    logic [11:0] r_out_hdl;
    logic [4:0]  r_out_slot;
    logic [14:0] r_out_stat;
    logic [5:0]  r_out_act;

    logic [IW-1:0] free_idx;
    logic          free_ok;
    logic [IW-1:0] key_ra;
    logic [7:0]    key_rd;
    logic [IW-1:0] key_slot;
    logic [IW-1:0] rd_idx;
    logic [12:0]   hdl_rd;
    logic [14:0]   stat_rd;
    logic          job_rd;
    logic          h_in_range;
    logic          hit;
    logic [14:0]   st_new;
    logic          report_ok;
    logic          launch_full;
    logic [11:0]   nh;
    logic          scan_end;
    logic          purge_end;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_idx = IW'(k);
                free_ok  = 1'b1;
            end
        end
    end

    assign key_ra   = i_cmd.ins_step ? IW'(r_i - CW'(1)) : r_i[IW-1:0];
    assign key_rd   = r_key[key_ra];
    assign key_slot = key_rd[IW-1:0];

    // single read port into the slot arrays
    always_comb begin
        if (i_cmd.exec) begin
            rd_idx = (r_cmd == pjst_pkg::CMD_LAUNCH) ? free_idx : r_h[IW-1:0];
        end else begin
            rd_idx = key_slot;
        end
    end

    assign hdl_rd  = r_hdl[rd_idx];
    assign stat_rd = r_stat[rd_idx];
    assign job_rd  = r_job[rd_idx];

    assign h_in_range = ({1'b0, r_h[4:0]} < 6'(SLOTS));
    assign hit = h_in_range && (r_h[12] ? !hdl_rd[12] : (hdl_rd == r_h));
    assign nh  = hdl_rd[11:0] + pjst_pkg::HANDLE_STEP;

    // run step status mapping
    always_comb begin
        if (r_sv[16]) begin
            st_new = (r_sv[15:0] < pjst_pkg::NEG_LIMIT_LO) ? pjst_pkg::ST_NEG_CLAMP
                                                           : {5'd0, r_sv[9:0]};
        end else if (r_sv[9:0] >= pjst_pkg::ST_DONE_MIN) begin
            st_new = {5'd0, r_sv[9:0]};
        end else begin
            st_new = r_sv[14:0];
        end
    end

    assign report_ok   = job_rd && !r_sv[16] && (r_sv[15:0] >= pjst_pkg::REPORT_MIN);
    assign launch_full = !free_ok || (r_len >= CW'(SLOTS));
    assign scan_end    = (r_i >= r_len);
    assign purge_end   = (r_i >= r_len);

    always_comb begin
        o_stat            = '0;
        o_stat.launch_ins = (r_cmd == pjst_pkg::CMD_LAUNCH) && !launch_full && r_ok;
        o_stat.is_run     = (r_cmd == pjst_pkg::CMD_RUN);
        o_stat.is_purge   = (r_cmd == pjst_pkg::CMD_PURGE);
        o_stat.ins_done   = (r_i == '0) || (key_rd[7:5] <= r_pc);
        o_stat.scan_done  = scan_end || (stat_rd <= pjst_pkg::ST_RUN_MAX);
        o_stat.purge_done = purge_end;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // run list keys: no reset, only entries below the length are read
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_step) begin
            if (o_stat.ins_done) begin
                r_key[r_i[IW-1:0]] <= {r_pc, 5'(r_slot)};
            end else begin
                r_key[r_i[IW-1:0]] <= key_rd;
            end
        end
        if (i_cmd.purge_step && !purge_end && (stat_rd[9:0] < pjst_pkg::ST_DONE_MIN)) begin
            r_key[r_keep[IW-1:0]] <= key_rd;
        end
    end

    // captured command fields and pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_h  <= i_handle;
            r_ok <= i_start_ok;
            r_pc <= i_priority_class;
            r_sv <= i_status_in;
        end
        if (i_cmd.exec) begin
            r_res_code <= pjst_pkg::RC_NO_EFFECT;
            r_res_hdl  <= '0;
            r_res_slot <= '0;
            r_res_stat <= '0;
            r_res_act  <= '0;
            unique case (r_cmd)
                pjst_pkg::CMD_LAUNCH: begin
                    if (launch_full) begin
                        r_res_code <= pjst_pkg::RC_FULL;
                    end else if (!r_ok) begin
                        r_res_code <= pjst_pkg::RC_START_BAD;
                        r_res_slot <= 5'(free_idx);
                    end else begin
                        r_res_code <= pjst_pkg::RC_OK;
                        r_res_hdl  <= nh;
                        r_res_slot <= 5'(free_idx);
                    end
                end
                pjst_pkg::CMD_LOOKUP, pjst_pkg::CMD_KILL, pjst_pkg::CMD_REPORT: begin
                    if (!hit) begin
                        r_res_code <= pjst_pkg::RC_MISS;
                        r_res_stat <= pjst_pkg::ST_MISS;
                    end else begin
                        r_res_slot <= r_h[4:0];
                        r_res_stat <= stat_rd;
                        if (r_cmd == pjst_pkg::CMD_LOOKUP) begin
                            r_res_code <= pjst_pkg::RC_OK;
                            r_res_hdl  <= hdl_rd[11:0];
                        end else if (r_cmd == pjst_pkg::CMD_KILL) begin
                            if (job_rd && (stat_rd[9:0] < pjst_pkg::ST_DONE_MIN)) begin
                                r_res_code <= pjst_pkg::RC_OK;
                                r_res_stat <= {5'd0, r_kill};
                            end
                        end else if (report_ok) begin
                            r_res_code <= pjst_pkg::RC_OK;
                            r_res_stat <= r_sv[14:0];
                        end
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.scan_step) begin
            if (scan_end) begin
                r_res_code <= pjst_pkg::RC_NO_RUN;
                r_res_slot <= '0;
                r_res_stat <= '0;
            end else if (stat_rd <= pjst_pkg::ST_RUN_MAX) begin
                r_res_code <= pjst_pkg::RC_OK;
                r_res_slot <= 5'(key_slot);
                r_res_stat <= st_new;
            end
        end
        if (i_cmd.purge_step && purge_end) begin
            r_res_code <= pjst_pkg::RC_OK;
            r_res_act  <= 6'(r_act);
        end
        if (i_cmd.out_load) begin
            r_out_code <= r_res_code;
            r_out_hdl  <= r_res_hdl;
            r_out_slot <= r_res_slot;
            r_out_stat <= r_res_stat;
            r_out_act  <= r_res_act;
        end
    end

    // slot table state, list length, walk counters, kill_status, command code, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_hdl[k]  <= pjst_pkg::HANDLE_BASE + 13'(k);
                r_stat[k] <= '0;
            end
            r_job       <= '0;
            r_used      <= '0;
            r_len       <= '0;
            r_kill      <= pjst_pkg::KILL_RESET;
            r_out_valid <= 1'b0;
            r_cmd       <= pjst_pkg::CMD_LAUNCH;
        end else begin
            if (i_cfg_we) r_kill <= i_cfg_data;
            if (i_cmd.capture) r_cmd <= i_cmd_code;

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.exec) begin
                unique case (r_cmd)
                    pjst_pkg::CMD_LAUNCH: begin
                        if (!launch_full) begin
                            r_stat[rd_idx] <= '0;
                            r_job[rd_idx]  <= r_ok;
                            if (r_ok) begin
                                r_hdl[rd_idx]  <= {1'b0, nh};
                                r_used[rd_idx] <= 1'b1;
                                r_slot         <= free_idx;
                                r_i            <= r_len;
                            end
                        end
                    end
                    pjst_pkg::CMD_KILL: begin
                        if (hit && job_rd && (stat_rd[9:0] < pjst_pkg::ST_DONE_MIN)) begin
                            r_stat[rd_idx] <= {5'd0, r_kill};
                        end
                    end
                    pjst_pkg::CMD_REPORT: begin
                        if (hit && report_ok) r_stat[rd_idx] <= r_sv[14:0];
                    end
                    pjst_pkg::CMD_RUN: begin
                        r_i <= '0;
                    end
                    pjst_pkg::CMD_PURGE: begin
                        r_i    <= '0;
                        r_keep <= '0;
                        r_act  <= '0;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.ins_step) begin
                if (o_stat.ins_done) begin
                    r_len <= r_len + CW'(1);
                end else begin
                    r_i <= r_i - CW'(1);
                end
            end

            if (i_cmd.scan_step && !scan_end) begin
                if (stat_rd <= pjst_pkg::ST_RUN_MAX) begin
                    r_stat[rd_idx] <= st_new;
                end else begin
                    r_i <= r_i + CW'(1);
                end
            end

            if (i_cmd.purge_step) begin
                if (purge_end) begin
                    r_len <= r_keep;
                end else begin
                    r_i <= r_i + CW'(1);
                    if (stat_rd[9:0] < pjst_pkg::ST_DONE_MIN) begin
                        r_keep <= r_keep + CW'(1);
                        if (stat_rd < pjst_pkg::ST_DONE_MIN15) r_act <= r_act + CW'(1);
                    end else begin
                        r_job[rd_idx]     <= 1'b0;
                        r_hdl[rd_idx][12] <= 1'b1;
                        r_used[rd_idx]    <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_code  = r_out_code;
    assign o_handle_out   = r_out_hdl;
    assign o_slot_out     = r_out_slot;
    assign o_job_status   = r_out_stat;
    assign o_active_count = r_out_act;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CW'(SLOTS))
        else $error("run list longer than the table");

    a_used_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == r_job)
        else $error("used map and job bits disagree");

    a_len_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.idle |-> ($countones(r_used) == int'(r_len)))
        else $error("run list length differs from used slot count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before it was taken");
`endif

endmodule
`default_nettype wire
